/* rtl/ogc_pkg.sv */
package ogc_pkg;

    // Coordinate widths hold any corner or any size the fields allow; corner plus size needs one more bit.
    localparam int XW      = 7;
    localparam int YW      = 6;
    localparam int ID_W    = 6;
    localparam int PX_W    = 6;
    localparam int PY_W    = 5;
    localparam int POS_W   = PX_W + PY_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_LEFT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_TOP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_ID   = 3'd4;

    typedef enum logic [1:0] {
        REQ_INIT  = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_DEL   = 2'd2,
        REQ_QUERY = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type         req_type;
        logic [PX_W-1:0]   pos_x;
        logic [PY_W-1:0]   pos_y;
        logic [6:0]        size_x;
        logic [5:0]        size_y;
        logic [ID_W-1:0]   obj_id;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [ID_W-1:0]   hit_id;
    } t_rsp;

    typedef struct packed {
        logic [6:0]        grid_width;
        logic [5:0]        grid_height;
        logic [6:0]        border_left;
        logic [5:0]        border_top;
        logic [ID_W-1:0]   canvas_id;
    } t_cfg;

    // Rectangle handed to the walk unit.
    typedef struct packed {
        logic [XW-1:0]     x0;
        logic [YW-1:0]     y0;
        logic [XW-1:0]     w;
        logic [YW-1:0]     h;
    } t_rect;

    // Grid extent after saturation to the built size.
    typedef struct packed {
        logic [XW-1:0]     cols;
        logic [YW-1:0]     rows;
    } t_ext;

    typedef struct packed {
        logic              load;
        logic              step;
    } t_walk_cmd;

    typedef struct packed {
        logic              busy;
        logic              fit;
    } t_walk_stat;

endpackage

/* rtl/ogc_ram.sv */
module ogc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                          i_wdata,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Single port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

/* rtl/ogc_rect_unit.sv */
module ogc_rect_unit #(
    parameter int GRID_COLS = 64,
    parameter int CELL_AW   = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ogc_pkg::t_rect     i_rect,
    input  ogc_pkg::t_ext      i_ext,
    input  ogc_pkg::t_walk_cmd i_cmd,
    output logic [CELL_AW-1:0] o_addr,
    output ogc_pkg::t_walk_stat o_stat
);

    import ogc_pkg::*;

    logic [XW:0]        xe_full;
    logic [YW:0]        ye_full;
    logic               fit;
    logic [XW-1:0]      r_x;
    logic [XW-1:0]      r_x0;
    logic [XW-1:0]      r_xe;
    logic [YW-1:0]      r_y;
    logic [YW-1:0]      r_ye;
    logic [CELL_AW-1:0] r_base;
    logic               r_busy;

    // Fit test: the far edge may not pass the grid extent on either axis.
    assign xe_full = {1'b0, i_rect.x0} + {1'b0, i_rect.w};
    assign ye_full = {1'b0, i_rect.y0} + {1'b0, i_rect.h};
    assign fit     = (xe_full <= {1'b0, i_ext.cols}) && (ye_full <= {1'b0, i_ext.rows});

    assign o_stat.fit  = fit;
    assign o_stat.busy = r_busy;
    assign o_addr      = r_base + CELL_AW'(r_x);

    // Cell walk, left to right inside a row, then down to the next row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.load) begin
            r_x    <= i_rect.x0;
            r_x0   <= i_rect.x0;
            r_xe   <= xe_full[XW-1:0];
            r_y    <= i_rect.y0;
            r_ye   <= ye_full[YW-1:0];
            r_base <= CELL_AW'(int'(i_rect.y0) * GRID_COLS);
            r_busy <= fit && (i_rect.w != '0) && (i_rect.h != '0);
        end else if (i_cmd.step && r_busy) begin
            if ((r_x + XW'(1)) == r_xe) begin
                r_x    <= r_x0;
                r_y    <= r_y + YW'(1);
                r_base <= r_base + CELL_AW'(GRID_COLS);
                if ((r_y + YW'(1)) == r_ye) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_x <= r_x + XW'(1);
            end
        end
    end

endmodule

/* rtl/ogc_ctrl.sv */
module ogc_ctrl #(
    parameter int GRID_COLS   = 64,
    parameter int GRID_ROWS   = 32,
    parameter int MAX_OBJECTS = 64,
    parameter int CELL_AW     = 11,
    parameter int POS_AW      = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ogc_pkg::t_cfg       i_cfg,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  ogc_pkg::t_req       i_req,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    output ogc_pkg::t_rsp       o_rsp,
    output ogc_pkg::t_rect      o_rect,
    output ogc_pkg::t_ext       o_ext,
    output ogc_pkg::t_walk_cmd  o_walk_cmd,
    input  ogc_pkg::t_walk_stat i_walk_stat,
    input  logic [CELL_AW-1:0]  i_walk_addr,
    output logic                o_cell_we,
    output logic [CELL_AW-1:0]  o_cell_addr,
    output logic [ogc_pkg::ID_W-1:0] o_cell_wdata,
    input  logic [ogc_pkg::ID_W-1:0] i_cell_rdata,
    output logic                o_pos_we,
    output logic [POS_AW-1:0]   o_pos_addr,
    output logic [ogc_pkg::POS_W-1:0] o_pos_wdata,
    input  logic [ogc_pkg::POS_W-1:0] i_pos_rdata
);

    import ogc_pkg::*;

    localparam int CELLS     = GRID_ROWS * GRID_COLS;
    localparam int CLR_DEPTH = (CELLS > MAX_OBJECTS) ? CELLS : MAX_OBJECTS;
    localparam int CLRW      = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
    localparam int IW        = (POS_AW > ID_W) ? POS_AW : ID_W;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_START,
        S_POS,
        S_BORDER,
        S_FILL,
        S_QUERY,
        S_OUT
    } t_state;

    t_state           r_state;
    t_req             r_req;
    logic [CLRW-1:0]  r_clr_cnt;
    logic             r_clr_pos;
    logic             r_top;
    logic [ID_W-1:0]  r_fill_id;
    logic             r_chk_vld;
    t_rsp             r_res;
    logic             r_out_vld;
    t_rsp             r_out;

    logic             id_ok;
    logic [IW-1:0]    id_ext;
    logic [POS_W-1:0] pos_sel;
    logic             hit;
    logic [CLRW-1:0]  clr_last;
    logic             out_free;

    // Grid extent saturated to the built size.
    assign o_ext.cols = (int'(i_cfg.grid_width) > GRID_COLS) ? XW'(GRID_COLS)
                                                            : i_cfg.grid_width;
    assign o_ext.rows = (int'(i_cfg.grid_height) > GRID_ROWS) ? YW'(GRID_ROWS)
                                                             : i_cfg.grid_height;

    // Ids beyond the position table have no entry of their own.
    assign id_ok   = int'(r_req.obj_id) < MAX_OBJECTS;
    assign id_ext  = IW'(r_req.obj_id);
    assign pos_sel = id_ok ? i_pos_rdata : '0;

    // A query hit is a checked cell held by some other object.
    assign hit = r_chk_vld && (i_cell_rdata != '0) && (i_cell_rdata != r_req.obj_id);

    assign clr_last = r_clr_pos ? CLRW'(CLR_DEPTH - 1) : CLRW'(CELLS - 1);
    assign out_free = !r_out_vld || i_rsp_ready;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;

    // Rectangle source and walk commands for each state.
    always_comb begin
        o_rect          = '0;
        o_walk_cmd.load = 1'b0;
        o_walk_cmd.step = 1'b0;
        unique case (r_state)
            S_START: begin
                o_rect.x0       = {1'b0, r_req.pos_x};
                o_rect.y0       = {1'b0, r_req.pos_y};
                o_rect.w        = r_req.size_x;
                o_rect.h        = r_req.size_y;
                o_walk_cmd.load = (r_req.req_type == REQ_ADD) || (r_req.req_type == REQ_QUERY);
            end
            S_POS: begin
                o_rect.x0       = {1'b0, pos_sel[PX_W-1:0]};
                o_rect.y0       = {1'b0, pos_sel[POS_W-1:PX_W]};
                o_rect.w        = r_req.size_x;
                o_rect.h        = r_req.size_y;
                o_walk_cmd.load = 1'b1;
            end
            S_BORDER: begin
                if (r_top) begin
                    o_rect.w = o_ext.cols;
                    o_rect.h = i_cfg.border_top;
                end else begin
                    o_rect.w = i_cfg.border_left;
                    o_rect.h = o_ext.rows;
                end
                o_walk_cmd.load = 1'b1;
            end
            S_FILL: begin
                o_walk_cmd.step = i_walk_stat.busy;
            end
            S_QUERY: begin
                o_walk_cmd.step = i_walk_stat.busy && !hit;
            end
            default: begin
            end
        endcase
    end

    // Memory port control: the clearing sweep owns both stores while it runs.
    always_comb begin
        o_cell_we    = 1'b0;
        o_cell_addr  = i_walk_addr;
        o_cell_wdata = r_fill_id;
        o_pos_we     = 1'b0;
        o_pos_addr   = id_ext[POS_AW-1:0];
        o_pos_wdata  = {r_req.pos_y, r_req.pos_x};
        unique case (r_state)
            S_CLR: begin
                o_cell_addr  = r_clr_cnt[CELL_AW-1:0];
                o_cell_wdata = '0;
                o_cell_we    = int'(r_clr_cnt) < CELLS;
                o_pos_addr   = r_clr_cnt[POS_AW-1:0];
                o_pos_wdata  = '0;
                o_pos_we     = r_clr_pos && (int'(r_clr_cnt) < MAX_OBJECTS);
            end
            S_START: begin
                o_pos_we = (r_req.req_type == REQ_ADD) && id_ok;
            end
            S_FILL: begin
                o_cell_we = i_walk_stat.busy;
            end
            default: begin
            end
        endcase
    end

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_cnt <= '0;
            r_clr_pos <= 1'b1;
            r_top     <= 1'b0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // The output state reloads the result register itself.
            if (r_out_vld && i_rsp_ready && (r_state != S_OUT)) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr_cnt <= r_clr_cnt + CLRW'(1);
                    if (r_clr_cnt == clr_last) begin
                        r_state <= r_clr_pos ? S_IDLE : S_BORDER;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req <= i_req;
                        if (i_req.req_type == REQ_INIT) begin
                            r_clr_cnt    <= '0;
                            r_clr_pos    <= 1'b0;
                            r_top        <= 1'b0;
                            r_res.ok     <= 1'b1;
                            r_res.hit_id <= '0;
                            r_state      <= S_CLR;
                        end else begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_fill_id <= r_req.obj_id;
                    r_chk_vld <= 1'b0;
                    unique case (r_req.req_type)
                        REQ_ADD: begin
                            r_res.ok     <= i_walk_stat.fit;
                            r_res.hit_id <= '0;
                            r_state      <= S_FILL;
                        end
                        REQ_DEL: begin
                            r_state <= S_POS;
                        end
                        REQ_QUERY: begin
                            if (i_walk_stat.fit) begin
                                r_res.ok     <= 1'b0;
                                r_res.hit_id <= '0;
                                r_state      <= S_QUERY;
                            end else begin
                                r_res.ok     <= 1'b1;
                                r_res.hit_id <= i_cfg.canvas_id;
                                r_state      <= S_OUT;
                            end
                        end
                        default: begin
                            r_res.ok     <= 1'b1;
                            r_res.hit_id <= '0;
                            r_state      <= S_OUT;
                        end
                    endcase
                end
                S_POS: begin
                    r_fill_id    <= '0;
                    r_res.ok     <= i_walk_stat.fit;
                    r_res.hit_id <= '0;
                    r_state      <= S_FILL;
                end
                S_BORDER: begin
                    r_fill_id <= i_cfg.canvas_id;
                    r_state   <= S_FILL;
                end
                S_FILL: begin
                    if (!i_walk_stat.busy) begin
                        if ((r_req.req_type == REQ_INIT) && !r_top) begin
                            r_top   <= 1'b1;
                            r_state <= S_BORDER;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_QUERY: begin
                    // One read in flight: issue the next cell while the last one is checked.
                    if (hit) begin
                        r_res.ok     <= 1'b1;
                        r_res.hit_id <= i_cell_rdata;
                        r_chk_vld    <= 1'b0;
                        r_state      <= S_OUT;
                    end else if (i_walk_stat.busy) begin
                        r_chk_vld <= 1'b1;
                    end else if (!r_chk_vld) begin
                        r_state <= S_OUT;
                    end else begin
                        r_chk_vld <= 1'b0;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out     <= r_res;
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/occupancy_grid_rect_collision_top.sv */
// Occupancy grid with rectangle fill and collision query. Each request
// (init, add, delete, query) is taken one at a time, and o_req_ready is high
// only while the sequencer is idle. A shared walk unit steps through the
// rectangle one cell per cycle over a single-port cell memory; a query
// stops at the first cell owned by another object, and a rectangle that does
// not fit is not walked. Init clears the whole cell memory, then paints the
// two border strips cell by cell. After reset a clearing pass empties the cell
// memory and the position table; no request is taken during it, while
// configuration writes are always taken. A finished result waits in an output
// register and the next request is accepted meanwhile.
module occupancy_grid_rect_collision_top #(
    parameter int GRID_COLS   = 64,
    parameter int GRID_ROWS   = 32,
    parameter int MAX_OBJECTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ogc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ogc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  ogc_pkg::t_req                 i_req,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    output ogc_pkg::t_rsp                 o_rsp
);

    import ogc_pkg::*;

    localparam int CELLS   = GRID_ROWS * GRID_COLS;
    localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int POS_AW  = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

    t_cfg               r_cfg;
    t_rect              rect;
    t_ext               ext;
    t_walk_cmd          walk_cmd;
    t_walk_stat         walk_stat;
    logic [CELL_AW-1:0] walk_addr;
    logic               cell_we;
    logic [CELL_AW-1:0] cell_addr;
    logic [ID_W-1:0]    cell_wdata;
    logic [ID_W-1:0]    cell_rdata;
    logic               pos_we;
    logic [POS_AW-1:0]  pos_addr;
    logic [POS_W-1:0]   pos_wdata;
    logic [POS_W-1:0]   pos_rdata;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_width  <= 7'd64;
            r_cfg.grid_height <= 6'd32;
            r_cfg.border_left <= 7'd1;
            r_cfg.border_top  <= 6'd1;
            r_cfg.canvas_id   <= 6'd63;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:  r_cfg.grid_width  <= i_cfg_data;
                CFG_GRID_HEIGHT: r_cfg.grid_height <= i_cfg_data[5:0];
                CFG_BORDER_LEFT: r_cfg.border_left <= i_cfg_data;
                CFG_BORDER_TOP:  r_cfg.border_top  <= i_cfg_data[5:0];
                CFG_CANVAS_ID:   r_cfg.canvas_id   <= i_cfg_data[ID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ogc_ctrl #(
        .GRID_COLS   (GRID_COLS),
        .GRID_ROWS   (GRID_ROWS),
        .MAX_OBJECTS (MAX_OBJECTS),
        .CELL_AW     (CELL_AW),
        .POS_AW      (POS_AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req        (i_req),
        .o_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .o_rsp        (o_rsp),
        .o_rect       (rect),
        .o_ext        (ext),
        .o_walk_cmd   (walk_cmd),
        .i_walk_stat  (walk_stat),
        .i_walk_addr  (walk_addr),
        .o_cell_we    (cell_we),
        .o_cell_addr  (cell_addr),
        .o_cell_wdata (cell_wdata),
        .i_cell_rdata (cell_rdata),
        .o_pos_we     (pos_we),
        .o_pos_addr   (pos_addr),
        .o_pos_wdata  (pos_wdata),
        .i_pos_rdata  (pos_rdata)
    );

    ogc_rect_unit #(
        .GRID_COLS (GRID_COLS),
        .CELL_AW   (CELL_AW)
    ) u_rect (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rect  (rect),
        .i_ext   (ext),
        .i_cmd   (walk_cmd),
        .o_addr  (walk_addr),
        .o_stat  (walk_stat)
    );

    // Cell owner store, one id per grid cell.
    ogc_ram #(
        .WIDTH (ID_W),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_addr  (cell_addr),
        .i_wdata (cell_wdata),
        .o_rdata (cell_rdata)
    );

    // Last recorded position of each object.
    ogc_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_OBJECTS)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_addr  (pos_addr),
        .i_wdata (pos_wdata),
        .o_rdata (pos_rdata)
    );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
    import ogc_pkg::*;

    localparam int NCOLS = 64;
    localparam int NROWS = 32;
    localparam int NOBJ  = 64;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_req_valid = 1'b0;
    logic                  o_req_ready;
    t_req                  i_req = '0;
    logic                  o_rsp_valid;
    logic                  i_rsp_ready = 1'b0;
    t_rsp                  o_rsp;

    occupancy_grid_rect_collision_top #(
        .GRID_COLS   (NCOLS),
        .GRID_ROWS   (NROWS),
        .MAX_OBJECTS (NOBJ)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    // Shadow copy of the grid, the position table and the registers.
    logic [ID_W-1:0]  grid_model [NCOLS*NROWS];
    logic [POS_W-1:0] pos_table [NOBJ];
    t_cfg             grid_cfg = '{7'd64, 6'd32, 7'd1, 6'd1, 6'd63};

    // Requests waiting to be driven and responses still owed by the block.
    t_req   req_backlog [$];
    t_rsp   rsp_due [$];

    // Sizes of the last add per id, so that most deletes match their add.
    int     placed_w [NOBJ];
    int     placed_h [NOBJ];
    int     last_id = 1;

    bit     no_idle = 1'b0;
    int     send_gap = 0;
    int     stall_left = 0;
    int     mismatch_count = 0;
    longint cycle_budget = 4000;
    longint cycle_count = 0;

    // Free-running clock.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int extent_cols();
        return (int'(grid_cfg.grid_width) > NCOLS) ? NCOLS : int'(grid_cfg.grid_width);
    endfunction

    function automatic int extent_rows();
        return (int'(grid_cfg.grid_height) > NROWS) ? NROWS : int'(grid_cfg.grid_height);
    endfunction

    // Fill a rectangle with one id; nothing changes when it overruns the extent.
    function automatic bit paint_rect(int x0, int y0, int w, int h, logic [ID_W-1:0] id);
        int xe;
        int ye;
        xe = x0 + w;
        ye = y0 + h;
        if (xe > extent_cols() || ye > extent_rows()) return 1'b0;
        for (int y = y0; y < ye; y++) begin
            for (int x = x0; x < xe; x++) begin
                grid_model[y*NCOLS + x] = id;
            end
        end
        return 1'b1;
    endfunction

    // Apply one request to the shadow grid and return the response it owes.
    function automatic t_rsp grid_predict(t_req r);
        t_rsp             res;
        logic [POS_W-1:0] p;
        logic [ID_W-1:0]  c;
        int               xe;
        int               ye;
        bit               found;
        res = '0;
        found = 1'b0;
        case (r.req_type)
            REQ_INIT: begin
                foreach (grid_model[i]) grid_model[i] = '0;
                void'(paint_rect(0, 0, int'(grid_cfg.border_left), extent_rows(),
                                 grid_cfg.canvas_id));
                void'(paint_rect(0, 0, extent_cols(), int'(grid_cfg.border_top),
                                 grid_cfg.canvas_id));
                res.ok = 1'b1;
            end
            REQ_ADD: begin
                if (int'(r.obj_id) < NOBJ) pos_table[r.obj_id] = {r.pos_y, r.pos_x};
                res.ok = paint_rect(int'(r.pos_x), int'(r.pos_y), int'(r.size_x),
                                    int'(r.size_y), r.obj_id);
            end
            REQ_DEL: begin
                p = (int'(r.obj_id) < NOBJ) ? pos_table[r.obj_id] : '0;
                res.ok = paint_rect(int'(p[PX_W-1:0]), int'(p[POS_W-1:PX_W]),
                                    int'(r.size_x), int'(r.size_y), '0);
            end
            default: begin
                xe = int'(r.pos_x) + int'(r.size_x);
                ye = int'(r.pos_y) + int'(r.size_y);
                if (xe > extent_cols() || ye > extent_rows()) begin
                    res.ok = 1'b1;
                    res.hit_id = grid_cfg.canvas_id;
                end else begin
                    // Row by row, the first cell held by another object wins.
                    for (int y = int'(r.pos_y); y < ye && !found; y++) begin
                        for (int x = int'(r.pos_x); x < xe && !found; x++) begin
                            c = grid_model[y*NCOLS + x];
                            if (c != '0 && c != r.obj_id) begin
                                found = 1'b1;
                                res.ok = 1'b1;
                                res.hit_id = c;
                            end
                        end
                    end
                end
            end
        endcase
        return res;
    endfunction

    // Idle lengths: mostly short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 2);
        if (r < 95) return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    // Rectangle sides: mostly small, a few up to the whole extent.
    function automatic int rand_len(int span);
        int cap;
        cap = (span < 8) ? span : 8;
        if ($urandom_range(0, 19) == 0) return $urandom_range(0, span);
        return $urandom_range(0, cap);
    endfunction

    function automatic int rand_corner(int span, int cap);
        return $urandom_range(0, (span > cap) ? cap : span);
    endfunction

    function automatic t_req make_req(t_req_type kind, int px, int py, int sx, int sy, int id);
        t_req r;
        r.req_type = kind;
        r.pos_x    = PX_W'(px);
        r.pos_y    = PY_W'(py);
        r.size_x   = 7'(sx);
        r.size_y   = 6'(sy);
        r.obj_id   = ID_W'(id);
        return r;
    endfunction

    // Random request: mostly well-formed rectangles inside the grid, some noise.
    function automatic t_req random_request();
        t_req r;
        int   pick;
        int   w;
        int   h;
        pick = $urandom_range(0, 99);
        r = '0;
        if (pick < 10) begin
            r.req_type = t_req_type'($urandom_range(0, 3));
            r.pos_x    = PX_W'($urandom_range(0, 63));
            r.pos_y    = PY_W'($urandom_range(0, 31));
            r.size_x   = 7'($urandom_range(0, 64));
            r.size_y   = 6'($urandom_range(0, 32));
            r.obj_id   = ID_W'($urandom_range(0, 63));
            return r;
        end
        w = rand_len(extent_cols());
        h = rand_len(extent_rows());
        r.size_x = 7'(w);
        r.size_y = 6'(h);
        r.pos_x  = PX_W'(rand_corner(extent_cols() - w, 63));
        r.pos_y  = PY_W'(rand_corner(extent_rows() - h, 31));
        if ($urandom_range(0, 9) == 0) begin
            r.pos_x = PX_W'($urandom_range(0, 63));
            r.pos_y = PY_W'($urandom_range(0, 31));
        end
        r.obj_id = ID_W'($urandom_range(1, 63));
        if (pick < 12) begin
            r.req_type = REQ_INIT;
        end else if (pick < 47) begin
            r.req_type = REQ_ADD;
            placed_w[r.obj_id] = w;
            placed_h[r.obj_id] = h;
            last_id = int'(r.obj_id);
        end else if (pick < 67) begin
            r.req_type = REQ_DEL;
            if ($urandom_range(0, 4) != 0) begin
                r.size_x = 7'(placed_w[r.obj_id]);
                r.size_y = 6'(placed_h[r.obj_id]);
            end
        end else begin
            r.req_type = REQ_QUERY;
            if ($urandom_range(0, 1) == 0) r.obj_id = ID_W'(last_id);
        end
        return r;
    endfunction

    // Queue a request and widen the time budget by its worst case.
    task automatic queue_req(t_req r);
        req_backlog.push_back(r);
        if (r.req_type == REQ_INIT) cycle_budget += 3*NCOLS*NROWS + 150;
        else cycle_budget += int'(r.size_x) * int'(r.size_y) + 150;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (req_backlog.size() != 0 || i_req_valid || rsp_due.size() != 0);
    endtask

    // One register write over the configuration channel.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_GRID_WIDTH:  grid_cfg.grid_width  = data;
            CFG_GRID_HEIGHT: grid_cfg.grid_height = data[5:0];
            CFG_BORDER_LEFT: grid_cfg.border_left = data;
            CFG_BORDER_TOP:  grid_cfg.border_top  = data[5:0];
            CFG_CANVAS_ID:   grid_cfg.canvas_id   = data[ID_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(int w, int h, int bl, int bt, int cid);
        write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_BORDER_LEFT, CFG_DATA_W'(bl));
        write_reg(CFG_BORDER_TOP, CFG_DATA_W'(bt));
        write_reg(CFG_CANVAS_ID, CFG_DATA_W'(cid));
        @(negedge i_clk);
    endtask

    // A setting of the grid, an init, then random requests in drained batches.
    task automatic run_phase(int w, int h, int bl, int bt, int cid, int n);
        int k;
        wait_idle();
        set_grid(w, h, bl, bt, cid);
        queue_req(make_req(REQ_INIT, 0, 0, 0, 0, 1));
        while (n > 0) begin
            k = (n > 40) ? 40 : n;
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (k) queue_req(random_request());
            wait_idle();
            n -= k;
        end
        no_idle = 1'b0;
    endtask

    // Request driver: presents the backlog one request at a time.
    always @(posedge i_clk) begin : req_driver
        bit fire;
        fire = i_req_valid && o_req_ready;
        if (i_rst_n) begin
            if (fire) begin
                rsp_due.push_back(grid_predict(i_req));
                send_gap = no_idle ? 0 : pick_gap();
            end
            if (!i_req_valid || fire) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_req_valid <= 1'b0;
                end else if (req_backlog.size() != 0) begin
                    i_req       <= req_backlog.pop_front();
                    i_req_valid <= 1'b1;
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: checks each response and stalls ready at random.
    always @(posedge i_clk) begin : rsp_monitor
        t_rsp want;
        if (i_rst_n) begin
            if (o_rsp_valid && i_rsp_ready) begin
                if (rsp_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 200)
                        $display("%0t: response with none owed: ok=%0d hit_id=%0d",
                                 $time, o_rsp.ok, o_rsp.hit_id);
                end else begin
                    want = rsp_due.pop_front();
                    if (o_rsp.ok !== want.ok || o_rsp.hit_id !== want.hit_id) begin
                        mismatch_count++;
                        if (mismatch_count <= 200)
                            $display("%0t: expected ok=%0d hit_id=%0d, actual ok=%0d hit_id=%0d",
                                     $time, want.ok, want.hit_id, o_rsp.ok, o_rsp.hit_id);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_rsp_ready <= 1'b0;
            end else begin
                i_rsp_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 7) == 0) stall_left = pick_gap();
            end
        end
    end

    // Watchdog sized from the worst case of everything queued so far.
    initial begin : watchdog
        while (cycle_count <= 4*cycle_budget + 20000) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("occupancy_grid_rect_collision_top: mismatch");
        $finish;
    end

    // Main sequence.
    initial begin : stimulus
        foreach (grid_model[i]) grid_model[i] = '0;
        foreach (pos_table[i]) pos_table[i] = '0;
        foreach (placed_w[i]) begin
            placed_w[i] = 0;
            placed_h[i] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests on the full default grid.
        set_grid(64, 32, 1, 1, 63);
        queue_req(make_req(REQ_QUERY, 0, 0, 4, 4, 5));     // empty grid after reset
        queue_req(make_req(REQ_INIT, 0, 0, 0, 0, 1));
        queue_req(make_req(REQ_QUERY, 0, 0, 64, 32, 5));   // meets the border
        queue_req(make_req(REQ_ADD, 10, 5, 4, 3, 5));
        queue_req(make_req(REQ_QUERY, 10, 5, 4, 3, 5));    // own cells are skipped
        queue_req(make_req(REQ_QUERY, 8, 4, 6, 6, 7));     // hits object 5
        queue_req(make_req(REQ_ADD, 62, 30, 4, 4, 9));     // overrun still records position
        queue_req(make_req(REQ_DEL, 0, 0, 2, 2, 9));
        queue_req(make_req(REQ_DEL, 0, 0, 1, 1, 20));      // never added: uses the origin
        queue_req(make_req(REQ_ADD, 63, 31, 0, 0, 3));     // empty rectangle at the far corner
        queue_req(make_req(REQ_ADD, 10, 5, 2, 2, 0));      // id zero empties cells
        queue_req(make_req(REQ_QUERY, 8, 4, 6, 6, 7));
        queue_req(make_req(REQ_QUERY, 60, 0, 8, 1, 7));    // overrun reports the canvas
        queue_req(make_req(REQ_QUERY, 63, 31, 64, 32, 63));
        queue_req(make_req(REQ_ADD, 0, 0, 64, 32, 1));     // whole grid
        queue_req(make_req(REQ_QUERY, 0, 0, 64, 32, 1));
        queue_req(make_req(REQ_DEL, 0, 0, 64, 32, 1));
        queue_req(make_req(REQ_QUERY, 5, 5, 0, 0, 2));
        queue_req(make_req(REQ_QUERY, 63, 31, 0, 1, 2));
        queue_req(make_req(REQ_ADD, 63, 31, 1, 1, 62));
        queue_req(make_req(REQ_QUERY, 63, 31, 1, 1, 1));
        queue_req(make_req(REQ_ADD, 31, 15, 7, 5, 42));
        queue_req(make_req(REQ_QUERY, 28, 12, 10, 10, 21));
        wait_idle();

        // Random phases over a range of grid settings.
        run_phase(64, 32, 1, 1, 63, 200);
        run_phase(8, 4, 0, 0, 1, 80);
        run_phase(100, 40, 64, 32, 42, 80);    // oversized extent, full borders
        run_phase(1, 1, 2, 2, 63, 40);         // borders overrun the grid
        run_phase($urandom_range(1, 64), $urandom_range(1, 32), $urandom_range(0, 8),
                  $urandom_range(0, 4), $urandom_range(1, 63), 120);
        run_phase(64, 32, 1, 1, 63, 60);

        wait_idle();
        repeat (64) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("occupancy_grid_rect_collision_top: match");
        else
            $display("occupancy_grid_rect_collision_top: mismatch");
        $finish;
    end

endmodule
